FILE: sv/dct2d_pkg.sv
// ----------------------------------------------------------------------------
// dct2d_pkg - shared types, constants and functions of the 2-D DCT block
// Holds the cosine table, the rounding and saturation helpers, the sequencer
// state type and the control bundle of the serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package dct2d_pkg;

  localparam int BLOCK_SIZE     = 8;
  localparam int COEF_FRAC_BITS = 14;
  localparam int NN             = BLOCK_SIZE * BLOCK_SIZE;
  localparam int IDX_W          = 3;
  localparam int ADDR_W         = 6;
  localparam int IN_W           = 12;
  localparam int PART_W         = 24;
  localparam int OUT_W          = 16;
  localparam int COEF_W         = 15;
  localparam int ACC_W          = 42;
  localparam int PART_FRAC      = 8;
  localparam int SH1            = COEF_FRAC_BITS - PART_FRAC;
  localparam int SH2            = COEF_FRAC_BITS + PART_FRAC;
  localparam int DATA_BITS      = PART_W;
  localparam int CNT_W          = 5;

  localparam logic signed [ACC_W-1:0] HALF1    = ACC_W'(1) <<< (SH1 - 1);
  localparam logic signed [ACC_W-1:0] HALF2    = ACC_W'(1) <<< (SH2 - 1);
  localparam logic signed [ACC_W-1:0] PART_MAX = (ACC_W'(1) <<< (PART_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] PART_MIN = -(ACC_W'(1) <<< (PART_W - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX  = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -(ACC_W'(1) <<< (OUT_W - 1));

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic clr;
  } mac_ctl_t;

  // Orthonormal DCT-II entry C(row, col) in Q1.14; fold the phase into [0, N].
  function automatic logic signed [COEF_W-1:0] coef_lookup(logic [IDX_W-1:0] row,
                                                           logic [IDX_W-1:0] col);
    logic [6:0]        prod;
    logic [3:0]        m;
    logic              neg;
    logic [COEF_W-1:0] mag;
    prod = {4'b0, row} * {3'b0, col, 1'b1};
    neg  = prod[4];
    m    = prod[3:0];
    if (m > 4'd8) begin
      m   = 4'(5'd16 - {1'b0, m});
      neg = ~neg;
    end
    case (m)
      4'd0:    mag = COEF_W'(8192);
      4'd1:    mag = COEF_W'(8035);
      4'd2:    mag = COEF_W'(7568);
      4'd3:    mag = COEF_W'(6811);
      4'd4:    mag = COEF_W'(5793);
      4'd5:    mag = COEF_W'(4551);
      4'd6:    mag = COEF_W'(3135);
      4'd7:    mag = COEF_W'(1598);
      default: mag = '0;
    endcase
    if (row == '0) begin
      mag = COEF_W'(5793);
      neg = 1'b0;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Round to nearest, ties away from zero, down to 8 fraction bits; saturate.
  function automatic logic signed [PART_W-1:0] round_part(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + HALF1 - $signed({{(ACC_W-1){1'b0}}, a[ACC_W-1]})) >>> SH1;
    if (r > PART_MAX)      r = PART_MAX;
    else if (r < PART_MIN) r = PART_MIN;
    return r[PART_W-1:0];
  endfunction

  // Round to an integer, ties away from zero; saturate to the output width.
  function automatic logic signed [OUT_W-1:0] round_out(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    r = (a + HALF2 - $signed({{(ACC_W-1){1'b0}}, a[ACC_W-1]})) >>> SH2;
    if (r > OUT_MAX)      r = OUT_MAX;
    else if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

endpackage

FILE: sv/dct2d_mac.sv
// ----------------------------------------------------------------------------
// dct2d_mac - bit-serial multiply-accumulate
// Takes the data operand one bit per cycle, LSB first, and adds the shifted
// coefficient into a wide accumulator; the sign bit subtracts.
// ----------------------------------------------------------------------------
module dct2d_mac import dct2d_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [PART_W-1:0] data,
  input  logic signed [COEF_W-1:0] coef,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  acc
);

  logic                    busy_r, busy_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PART_W-1:0]       d_r, d_nxt;
  logic signed [ACC_W-1:0] pp_r, pp_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    d_r   <= d_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    pp_nxt   = pp_r;
    acc_nxt  = acc_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      d_nxt    = data;
      pp_nxt   = {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};
      if (ctl.clr) acc_nxt = '0;
    end else if (busy_r) begin
      if (d_r[0]) begin
        acc_nxt = (cnt_r == CNT_W'(DATA_BITS - 1)) ? acc_r - pp_r : acc_r + pp_r;
      end
      pp_nxt  = pp_r <<< 1;
      d_nxt   = d_r >> 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_BITS - 1)) busy_nxt = 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = acc_r;

endmodule

FILE: sv/dct_2d_block_transform.sv
// ----------------------------------------------------------------------------
// dct_2d_block_transform - 8x8 orthonormal 2-D DCT-II / inverse DCT
// Row-column transform built on one bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_value): one 12-bit signed element per
//   beat, row-major; 64 beats make one block. in_ready is high while loading.
//   Config channel (cfg_valid/cfg_ready/cfg_direction): always ready; writes
//   the direction (0 forward, 1 inverse). Direction is sampled when the last
//   element of a block is accepted.
//   Output channel (out_valid/out_ready/out_result/out_last_of_block): 64
//   beats per block, row-major, 16-bit saturated; last beat is marked.
//   Sequence: each dot-product term passes through ST_READ (memory read),
//   ST_START, the bit-serial MAC run over the 24-bit operand and the MAC
//   dropping busy in ST_WAIT; each of the 128 dot products (two passes of
//   64) has 8 terms plus an ST_FIN step. The serial MAC dominates the block
//   time. A new block is loaded only after the last result of the previous
//   one has been handed to the output register.
//   Reset: control state clears, direction returns to forward, loading
//   restarts at element 0. Memories hold no reset value.
//   Stall: a pending result sits in the output register; the sequencer holds
//   in its finish step until the register is free, so nothing is dropped.
// ----------------------------------------------------------------------------
module dct_2d_block_transform import dct2d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_result,
  output logic                    out_last_of_block,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_direction
);

  // Sample and partial-product stores
  logic signed [IN_W-1:0]   in_mem   [NN];
  logic signed [PART_W-1:0] part_mem [NN];
  logic signed [IN_W-1:0]   in_q_r;
  logic signed [PART_W-1:0] part_q_r;

  seq_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [ADDR_W-1:0]  o_r, o_nxt;          // current output element (row, col)
  logic [IDX_W-1:0]   t_r, t_nxt;          // term index of the dot product
  logic               stage_r, stage_nxt;  // 0 first pass, 1 second pass
  logic               dir_r, blk_dir_r, blk_dir_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_result_r, out_result_nxt;
  logic               out_last_r, out_last_nxt;

  logic [ADDR_W-1:0]       rd_addr;
  logic [IDX_W-1:0]        first_idx, c_row, c_col;
  logic signed [COEF_W-1:0] coef;
  logic signed [PART_W-1:0] mac_data;
  mac_ctl_t                mac_ctl;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    in_acc, part_wr;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Stage one reads column k of X; stage two reads row i of P.
  assign rd_addr   = stage_r ? {o_r[ADDR_W-1:IDX_W], t_r} : {t_r, o_r[IDX_W-1:0]};
  // Stage one uses C(i,t), stage two C(k,t); inverse transposes both.
  assign first_idx = stage_r ? o_r[IDX_W-1:0] : o_r[ADDR_W-1:IDX_W];
  assign c_row     = blk_dir_r ? t_r : first_idx;
  assign c_col     = blk_dir_r ? first_idx : t_r;
  assign coef      = coef_lookup(c_row, c_col);
  assign mac_data  = stage_r ? part_q_r : {{(PART_W-IN_W){in_q_r[IN_W-1]}}, in_q_r};

  dct2d_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .data  (mac_data),
    .coef  (coef),
    .busy  (mac_busy),
    .acc   (mac_acc)
  );

  // Memories: one write port each, registered read at the shared address
  always_ff @(posedge clk) begin
    if (in_acc) in_mem[load_cnt_r] <= in_value;
    if (part_wr) part_mem[o_r] <= round_part(mac_acc);
    in_q_r   <= in_mem[rd_addr];
    part_q_r <= part_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      o_r         <= '0;
      t_r         <= '0;
      stage_r     <= 1'b0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      o_r         <= o_nxt;
      t_r         <= t_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) dir_r <= cfg_direction;
    end
    blk_dir_r    <= blk_dir_nxt;
    out_result_r <= out_result_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    o_nxt          = o_r;
    t_nxt          = t_r;
    stage_nxt      = stage_r;
    blk_dir_nxt    = blk_dir_r;
    out_result_nxt = out_result_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    part_wr        = 1'b0;
    mac_ctl.start  = 1'b0;
    mac_ctl.clr    = (t_r == '0);
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load_cnt_nxt = load_cnt_r + ADDR_W'(1);
          if (load_cnt_r == ADDR_W'(NN - 1)) begin
            // block complete: latch direction and start the first pass
            blk_dir_nxt = dir_r;
            stage_nxt   = 1'b0;
            o_nxt       = '0;
            t_nxt       = '0;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        mac_ctl.start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (!mac_busy) begin
          if (t_r == IDX_W'(BLOCK_SIZE - 1)) begin
            state_nxt = ST_FIN;
          end else begin
            t_nxt     = t_r + IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      ST_FIN: begin
        if (!stage_r) begin
          part_wr   = 1'b1;
          t_nxt     = '0;
          state_nxt = ST_READ;
          if (o_r == ADDR_W'(NN - 1)) begin
            stage_nxt = 1'b1;
            o_nxt     = '0;
          end else begin
            o_nxt = o_r + ADDR_W'(1);
          end
        end else if (!out_valid_r || out_ready) begin
          // output register free: hand over one result beat
          out_valid_nxt  = 1'b1;
          out_result_nxt = round_out(mac_acc);
          out_last_nxt   = (o_r == ADDR_W'(NN - 1));
          t_nxt          = '0;
          if (o_r == ADDR_W'(NN - 1)) begin
            o_nxt     = '0;
            state_nxt = ST_LOAD;
          end else begin
            o_nxt     = o_r + ADDR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_last_of_block = out_last_r;

endmodule
